// File: src/efws_pkg.sv
package efws_pkg;

  localparam int LEN_W    = 31;
  localparam int TIME_W   = 63;
  localparam int CFG_W    = 5;
  localparam int WORKER_W = 4;

  localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
  localparam logic [CFG_W-1:0]  CFG_RESET = 5'd16;

  typedef struct packed {
    logic [LEN_W-1:0] job_length;
    logic             new_batch;
  } job_t;

  typedef struct packed {
    logic [WORKER_W-1:0] chosen_worker;
    logic [TIME_W-1:0]   job_start;
  } result_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic clear;
    logic active;
    logic wr_en;
  } cell_ctl_t;

endpackage

// File: src/earliest_free_worker_scheduler.sv
// Earliest-free worker scheduler. Each job transfer is given to the active
// worker whose free time is lowest (lowest index on ties); the result carries
// that worker and its old free time as the job start, and the worker's free
// time then grows by the job length, saturating at 2^63-1. new_batch clears
// every free time before the job is placed. Free times live in a row of
// MAX_WORKERS cells; a search token walks the row one cell per cycle, and a
// new job is not taken until the token of the last one has left the row and
// its result is written back. A finished result waits in an output register;
// the next job is taken as soon as its write-back is done. The user must write
// active_workers through cfg_we/cfg_wdata only while idle; the block does not
// enforce this. 0 acts as 1 and values above MAX_WORKERS act as MAX_WORKERS.
// Workers outside the active range keep their free times.
module earliest_free_worker_scheduler #(
  parameter int MAX_WORKERS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  efws_pkg::job_t               job,
  input  logic                         job_valid,
  output logic                         job_ready,
  output efws_pkg::result_t            result,
  output logic                         result_valid,
  input  logic                         result_ready,
  input  logic                         cfg_we,
  input  logic [efws_pkg::CFG_W-1:0]   cfg_wdata
);
  import efws_pkg::*;

  localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;

  // configuration
  logic [CFG_W-1:0] active_workers;

  // sequencer state
  logic             busy;
  logic             inj_vld;
  logic [LEN_W-1:0] len_q;

  // chain tail capture
  logic              tail_vld;
  logic [TIME_W-1:0] tail_time;
  logic [IDX_W-1:0]  tail_idx;

  // chain links, link 0 is the injected token
  logic              link_vld  [MAX_WORKERS+1];
  logic [TIME_W-1:0] link_time [MAX_WORKERS+1];
  logic [IDX_W-1:0]  link_idx  [MAX_WORKERS+1];

  logic              job_xfer;
  logic              fire;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] new_time;
  logic [IDX_W+WORKER_W-1:0] idx_ext;

  // no transfer is taken while reset is held
  assign job_ready = !busy && !rst;
  assign job_xfer  = job_valid && job_ready;

  // write-back and result load happen together, only when the output slot frees
  assign fire = tail_vld && (!result_valid || result_ready);

  // saturating add of the job length to the chosen start time
  assign sum      = {1'b0, tail_time} + (TIME_W+1)'(len_q);
  assign new_time = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  assign idx_ext  = {{WORKER_W{1'b0}}, tail_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      active_workers <= CFG_RESET;
    end else if (cfg_we) begin
      active_workers <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      inj_vld <= 1'b0;
    end else begin
      // token enters the row the cycle after the transfer, after any clear
      inj_vld <= job_xfer;
      if (job_xfer) begin
        busy <= 1'b1;
      end else if (fire) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_xfer) begin
      len_q <= job.job_length;
    end
  end

  // search token starts at worker 0 with the largest time, so worker 0 wins
  // whenever nothing lower is found
  assign link_vld[0]  = inj_vld;
  assign link_time[0] = TIME_MAX;
  assign link_idx[0]  = '0;

  for (genvar i = 0; i < MAX_WORKERS; i++) begin : g_cell
    cell_ctl_t ctl;

    assign ctl.clear  = job_xfer && job.new_batch;
    assign ctl.active = (i == 0) || (32'(active_workers) > i);
    assign ctl.wr_en  = fire && (tail_idx == IDX_W'(i));

    efws_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .wr_time  (new_time),
      .in_vld   (link_vld[i]),
      .in_time  (link_time[i]),
      .in_idx   (link_idx[i]),
      .out_vld  (link_vld[i+1]),
      .out_time (link_time[i+1]),
      .out_idx  (link_idx[i+1])
    );
  end

  // hold the search result until the output register can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      tail_vld <= 1'b0;
    end else if (link_vld[MAX_WORKERS]) begin
      tail_vld <= 1'b1;
    end else if (fire) begin
      tail_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (link_vld[MAX_WORKERS]) begin
      tail_time <= link_time[MAX_WORKERS];
      tail_idx  <= link_idx[MAX_WORKERS];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.chosen_worker <= idx_ext[WORKER_W-1:0];
      result.job_start     <= tail_time;
    end
  end

endmodule

// File: src/efws_cell.sv
module efws_cell #(
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  efws_pkg::cell_ctl_t           ctl,
  input  logic [efws_pkg::TIME_W-1:0]   wr_time,
  input  logic                          in_vld,
  input  logic [efws_pkg::TIME_W-1:0]   in_time,
  input  logic [IDX_W-1:0]              in_idx,
  output logic                          out_vld,
  output logic [efws_pkg::TIME_W-1:0]   out_time,
  output logic [IDX_W-1:0]              out_idx
);
  import efws_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [TIME_W-1:0] free_time;
  logic              take;

  // strict less-than keeps the lower index on ties
  assign take = ctl.active && (free_time < in_time);

  always_ff @(posedge clk) begin
    if (rst) begin
      free_time <= '0;
    end else if (ctl.clear) begin
      free_time <= '0;
    end else if (ctl.wr_en) begin
      free_time <= wr_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld) begin
      if (take) begin
        out_time <= free_time;
        out_idx  <= MY_IDX;
      end else begin
        out_time <= in_time;
        out_idx  <= in_idx;
      end
    end
  end

endmodule

// File: tb/assignment_checker.sv
module assignment_checker #(
  parameter int MAX_WORKERS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  efws_pkg::job_t             job,
  input  logic                       job_valid,
  input  logic                       job_ready,
  input  efws_pkg::result_t          result,
  input  logic                       result_valid,
  input  logic                       result_ready,
  input  logic                       cfg_we,
  input  logic [efws_pkg::CFG_W-1:0] cfg_wdata,
  output int                         outstanding,
  output int                         mismatches
);

  import efws_pkg::*;

  logic [TIME_W-1:0] free_time [MAX_WORKERS];
  logic [CFG_W-1:0]  worker_setting;
  result_t           expected_assignments [$];
  result_t           want;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // earliest free active worker wins, lowest index on ties
  task automatic place_job(input job_t j);
    int unsigned       span;
    int unsigned       best;
    logic [TIME_W:0]   sum;
    result_t           r;
    if (worker_setting == 0)
      span = 1;
    else if (worker_setting > MAX_WORKERS)
      span = MAX_WORKERS;
    else
      span = 32'(worker_setting);
    if (j.new_batch)
      foreach (free_time[i]) free_time[i] = '0;
    best = 0;
    for (int i = 1; i < span; i++)
      if (free_time[i] < free_time[best]) best = i;
    r.chosen_worker = best[WORKER_W-1:0];
    r.job_start     = free_time[best];
    sum = {1'b0, free_time[best]} + {{(TIME_W + 1 - LEN_W){1'b0}}, j.job_length};
    if (sum > {1'b0, TIME_MAX})
      free_time[best] = TIME_MAX;
    else
      free_time[best] = sum[TIME_W-1:0];
    expected_assignments.push_back(r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (free_time[i]) free_time[i] = '0;
      worker_setting = CFG_RESET;
      expected_assignments.delete();
    end else begin
      if (cfg_we) worker_setting = cfg_wdata;
      if (result_valid && result_ready) begin
        if (expected_assignments.size() == 0) begin
          report_mismatch($sformatf("unexpected result: worker %0d start %0d",
                                    result.chosen_worker, result.job_start));
        end else begin
          want = expected_assignments.pop_front();
          if (result.chosen_worker !== want.chosen_worker)
            report_mismatch($sformatf("chosen_worker %0d, expected %0d",
                                      result.chosen_worker, want.chosen_worker));
          if (result.job_start !== want.job_start)
            report_mismatch($sformatf("job_start %0d, expected %0d",
                                      result.job_start, want.job_start));
        end
      end
      if (job_valid && job_ready) place_job(job);
    end
    outstanding <= expected_assignments.size();
  end

endmodule

// File: tb/tb.sv
module tb;

  import efws_pkg::*;

  localparam int                WORKERS      = 16;
  localparam int                CYCLE_LIMIT  = 400000;
  localparam int                HOLDOFF_LEN  = 300;
  localparam int                PHASE_COUNT  = 8;
  localparam int                PHASE_JOBS   = 216;
  localparam logic [LEN_W-1:0]  LEN_MAX      = '1;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  job_t             job = '0;
  logic             job_valid = 1'b0;
  logic             job_ready;
  result_t          result;
  logic             result_valid;
  logic             result_ready = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  int outstanding;
  int mismatches;
  int cycle_count = 0;
  int jobs_sent = 0;
  int cfg_writes = 0;

  // idle mix, written with nonblocking assignments between phases
  int send_idle_pct = 0;
  int stall_pct = 0;

  // a rising edge here starts one long output hold-off
  logic pressure_on = 1'b0;
  logic pressure_seen = 1'b0;
  int   holdoff_left = 0;

  // 8 time unit period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  earliest_free_worker_scheduler #(
    .MAX_WORKERS (WORKERS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .job          (job),
    .job_valid    (job_valid),
    .job_ready    (job_ready),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  // watches both channels and the register port, predicts and compares
  assignment_checker #(
    .MAX_WORKERS (WORKERS)
  ) assign_check (
    .clk          (clk),
    .rst          (rst),
    .job          (job),
    .job_valid    (job_valid),
    .job_ready    (job_ready),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .outstanding  (outstanding),
    .mismatches   (mismatches)
  );

  // run limit, far above the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  // into its input while the sender keeps offering
  always @(posedge clk) begin
    if (pressure_on && !pressure_seen)
      holdoff_left = HOLDOFF_LEN;
    pressure_seen = pressure_on;
    if (holdoff_left > 0) begin
      result_ready <= 1'b0;
      holdoff_left--;
    end else begin
      result_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic job_t job_of(input logic [LEN_W-1:0] len, input logic batch);
    job_t j;
    j.job_length = len;
    j.new_batch  = batch;
    return j;
  endfunction

  // short lengths make ties common, long ones spread the free times apart
  function automatic job_t random_job();
    job_t j;
    case ($urandom_range(9))
      0:       j.job_length = '0;
      1:       j.job_length = LEN_MAX;
      2, 3:    j.job_length = LEN_W'($urandom_range(15));
      4, 5:    j.job_length = LEN_W'($urandom_range(1000));
      default: j.job_length = LEN_W'($urandom_range(LEN_MAX));
    endcase
    j.new_batch = ($urandom_range(19) == 0);
    return j;
  endfunction

  // offer one job, with random idle cycles ahead of it, and wait for the transfer;
  // valid is left high so back-to-back jobs never drop it
  task automatic send_job(input job_t j);
    while ($urandom_range(99) < send_idle_pct) begin
      job_valid <= 1'b0;
      @(posedge clk);
    end
    job       <= j;
    job_valid <= 1'b1;
    do @(posedge clk); while (!job_ready);
    jobs_sent++;
  endtask

  // stop offering, wait for every expected result, then let the block settle
  task automatic drain(input int settle);
    job_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (settle) @(posedge clk);
  endtask

  // register writes only happen with the block idle
  task automatic set_workers(input logic [CFG_W-1:0] count);
    drain(4);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_writes++;
  endtask

  task automatic set_mix(input int mode);
    case (mode)
      0: begin send_idle_pct <= 0;  stall_pct <= 0;  end
      1: begin send_idle_pct <= 57; stall_pct <= 0;  end
      2: begin send_idle_pct <= 0;  stall_pct <= 57; end
      default: begin send_idle_pct <= 16; stall_pct <= 16; end
    endcase
  endtask

  function automatic logic [CFG_W-1:0] phase_workers(input int p);
    case (p)
      0: return 5'd16;
      1: return 5'd1;
      2: return 5'd5;
      3: return 5'd0;
      4: return 5'd31;
      5: return 5'd12;
      6: return 5'd17;
      default: return 5'd2;
    endcase
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, worker count still at its reset value of sixteen
    send_job(job_of('0, 1'b0));        // zero-length job leaves worker 0 free
    send_job(job_of('0, 1'b0));        // so worker 0 is picked again at once
    send_job(job_of(LEN_MAX, 1'b0));   // longest job parks worker 0
    repeat (3) send_job(job_of(31'd7, 1'b0));
    send_job(job_of(31'd3, 1'b1));     // new batch wipes all free times

    set_workers(5'd0);                 // zero count behaves as one worker
    send_job(job_of(31'd10, 1'b0));
    send_job(job_of(LEN_MAX, 1'b0));
    send_job(job_of(31'd1, 1'b0));

    set_workers(5'd31);                // above the maximum, clamps to sixteen
    repeat (3) send_job(job_of(31'd2, 1'b0));

    set_workers(5'd3);                 // shrink mid-batch, upper workers keep times
    repeat (4) send_job(job_of(31'd5, 1'b0));

    set_workers(5'd16);                // widen again, parked times come back
    repeat (3) send_job(job_of(31'd1, 1'b0));
    send_job(job_of(LEN_MAX, 1'b1));

    // random part: one worker count and one idle mix per phase, no batch
    // restart between phases so the count also changes mid-batch
    for (int p = 0; p < PHASE_COUNT; p++) begin
      set_mix(p % 4);
      set_workers(phase_workers(p));
      if (p == 2)
        pressure_on <= 1'b1;
      for (int k = 0; k < PHASE_JOBS; k++)
        send_job(random_job());
    end

    drain(2 * WORKERS + 8);

    $display("%0d job transfers checked over %0d worker-count writes (0, 1, 31 among them),",
             jobs_sent, cfg_writes);
    $display("under four idle mixes and one long output hold-off");
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// File: sim.f
src/efws_pkg.sv
src/efws_cell.sv
src/earliest_free_worker_scheduler.sv
tb/assignment_checker.sv
tb/tb.sv
